FILE: hdl/swc_pkg.sv
// Shared types and constants for the staircase ways counter.
// No dependencies.
package swc_pkg;

    localparam int STEP_W = 6;
    localparam int WAYS_W = 32;

    typedef struct packed {
        logic [STEP_W-1:0] stairs;
        logic [STEP_W-1:0] max_step;
    } swc_in_t;

    typedef struct packed {
        logic [WAYS_W-1:0] ways;
        logic              overflow;
    } swc_out_t;

endpackage

FILE: hdl/swc_table_ram.sv
// Ways table storage: one write port, one read port, registered read data.
// No dependencies.
module swc_table_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/staircase_ways_counter_unit.sv
// Staircase ways counter: top level with window-sum sequencer; uses swc_pkg, swc_table_ram.
// Each query walks table entries 0..n (n = clamped stairs); a new input beat is
// taken only once the result is registered. One table entry per cycle, set by the
// single table read port feeding the window sum; the last entry waits while the output is full.
// Reset: synchronous active-low aresetn clears control and the output valid;
// the table needs no clearing since every query rewrites entries 0..n.
module staircase_ways_counter_unit #(
    parameter int MAX_STAIRS  = 63,
    parameter int COUNT_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  swc_pkg::swc_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output swc_pkg::swc_out_t m_data
);
    import swc_pkg::*;

    localparam int DEPTH = MAX_STAIRS + 1;
    localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = ((IDX_W > STEP_W) ? IDX_W : STEP_W) + 1;
    localparam int WIN_W = COUNT_WIDTH + STEP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       m_reg, m_next;
    logic [STEP_W-1:0]      k_reg, k_next;
    logic [WIN_W-1:0]       win_reg, win_next;
    logic [COUNT_WIDTH-1:0] prev_reg, prev_next;
    logic                   sat_reg, sat_next;
    logic                   m_valid_reg, m_valid_next;
    swc_out_t               out_reg, out_next;

    logic [CMP_W-1:0]       stairs_ext, m_ext, k_ext, rd_pos;
    logic [COUNT_WIDTH-1:0] cur, drop, add, rd_data;
    logic                   win_over, drop_en, rd_ok, last, out_free, step;
    logic [IDX_W-1:0]       rd_addr;

    assign stairs_ext = CMP_W'(s_data.stairs);
    assign m_ext      = CMP_W'(m_reg);
    assign k_ext      = CMP_W'(k_reg);
    assign win_over   = (win_reg[WIN_W-1:COUNT_WIDTH] != '0);
    assign cur        = (m_reg == '0) ? COUNT_WIDTH'(1) :
                        (win_over ? {COUNT_WIDTH{1'b1}} : win_reg[COUNT_WIDTH-1:0]);
    assign drop_en    = (k_reg != '0) && (m_ext >= k_ext);
    assign drop       = !drop_en ? '0 : ((k_reg == STEP_W'(1)) ? prev_reg : rd_data);
    assign add        = (k_reg != '0) ? cur : '0;
    assign rd_pos     = m_ext + CMP_W'(1) - k_ext;
    assign rd_ok      = (k_reg != '0) && (m_ext + CMP_W'(1) >= k_ext);
    assign rd_addr    = rd_ok ? rd_pos[IDX_W-1:0] : '0;
    assign last       = (m_reg == n_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign step       = (state_reg == ST_RUN) && (!last || out_free);

    swc_table_ram #(
        .DEPTH (DEPTH),
        .WIDTH (COUNT_WIDTH),
        .AW    (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (step),
        .wr_addr (m_reg),
        .wr_data (cur),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        m_next       = m_reg;
        k_next       = k_reg;
        win_next     = win_reg;
        prev_next    = prev_reg;
        sat_next     = sat_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next     = (stairs_ext > CMP_W'(MAX_STAIRS)) ?
                                 IDX_W'(MAX_STAIRS) : IDX_W'(s_data.stairs);
                    k_next     = s_data.max_step;
                    m_next     = '0;
                    win_next   = '0;
                    sat_next   = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step) begin
                    prev_next = cur;
                    win_next  = win_reg + WIN_W'(add) - WIN_W'(drop);
                    if (last) begin
                        m_valid_next     = 1'b1;
                        out_next.ways    = WAYS_W'(cur);
                        out_next.overflow = sat_reg || ((m_reg != '0) && win_over);
                        state_next       = ST_IDLE;
                    end else begin
                        sat_next = sat_reg || ((m_reg != '0) && win_over);
                        m_next   = m_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            sat_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            sat_reg     <= sat_next;
        end
        n_reg    <= n_next;
        m_reg    <= m_next;
        k_reg    <= k_next;
        win_reg  <= win_next;
        prev_reg <= prev_next;
        out_reg  <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: dv/swc_checker.sv
// Scoreboard for the staircase ways counter: predicts ways/overflow for each
// accepted input beat and compares every accepted result beat in order.
// Depends on swc_pkg.
module swc_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  swc_pkg::swc_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  swc_pkg::swc_out_t m_data,
    output int                miss_count,
    output int                due_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import swc_pkg::*;

    localparam int STAIRS_CAP = 63;

    swc_out_t ways_due[$];
    int       misses = 0;

    function automatic swc_out_t climb_ways(input swc_in_t query);
        logic [WAYS_W-1:0] tbl [0:STAIRS_CAP];
        logic [WAYS_W:0]   sum;
        logic [WAYS_W-1:0] acc;
        int                n;
        int                k;
        swc_out_t          res;
        n = query.stairs;
        k = query.max_step;
        if (n > STAIRS_CAP) n = STAIRS_CAP;
        res.overflow = 1'b0;
        tbl[0] = WAYS_W'(1);
        for (int m = 1; m <= n; m++) begin
            acc = '0;
            for (int s = 1; s <= k && s <= m; s++) begin
                sum = {1'b0, acc} + tbl[m-s];
                if (sum[WAYS_W]) begin
                    acc          = '1;
                    res.overflow = 1'b1;
                end else begin
                    acc = sum[WAYS_W-1:0];
                end
            end
            tbl[m] = acc;
        end
        res.ways = tbl[n];
        return res;
    endfunction

    always @(posedge aclk) begin
        swc_out_t want;
        if (!aresetn) begin
            ways_due.delete();
        end else begin
            if (s_valid && s_ready) ways_due.push_back(climb_ways(s_data));
            if (m_valid && m_ready) begin
                if (ways_due.size() == 0) begin
                    misses++;
                    if (misses <= 10)
                        $display("unexpected result beat: ways=%0d overflow=%0b",
                                 m_data.ways, m_data.overflow);
                end else begin
                    want = ways_due.pop_front();
                    if (m_data.ways !== want.ways || m_data.overflow !== want.overflow) begin
                        misses++;
                        if (misses <= 10)
                            $display({"result beat differs: ways exp=%0d got=%0d, ",
                                      "overflow exp=%0b got=%0b"},
                                     want.ways, m_data.ways, want.overflow, m_data.overflow);
                    end
                end
            end
        end
        miss_count <= misses;
        due_count  <= ways_due.size();
    end

endmodule

FILE: dv/tb_top.sv
// Top of the staircase ways counter testbench: clock, reset, query stimulus
// with bursty sender and stalling receiver, and the final verdict.
// Depends on swc_pkg, staircase_ways_counter_unit and swc_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import swc_pkg::*;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    swc_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    swc_out_t m_data;
    int       miss_count;
    int       due_count;

    int       burst_left = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       stall_left = 0;

    staircase_ways_counter_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    swc_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .miss_count (miss_count),
        .due_count  (due_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("staircase_ways_counter_unit: mismatch");
        $finish;
    end

    // receiver: ready pattern switches among open, mostly, sparse and bursty modes
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 40) : 0;
                end
            end
        endcase
    end

    task automatic push_query(input swc_in_t query);
        int gap;
        s_data  <= query;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
    endtask

    function automatic swc_in_t make_query(input int n, input int k);
        swc_in_t q;
        q.stairs   = n[STEP_W-1:0];
        q.max_step = k[STEP_W-1:0];
        return q;
    endfunction

    initial begin
        int      pick;
        int      n;
        int      k;
        swc_in_t q;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero step, zero stairs, step past target,
        // saturation boundaries
        push_query(make_query(0, 0));
        push_query(make_query(0, 63));
        push_query(make_query(63, 0));
        push_query(make_query(1, 0));
        push_query(make_query(63, 63));
        push_query(make_query(63, 1));
        push_query(make_query(1, 1));
        push_query(make_query(1, 63));
        push_query(make_query(5, 63));
        push_query(make_query(2, 2));
        push_query(make_query(3, 5));
        push_query(make_query(10, 3));
        push_query(make_query(20, 4));
        push_query(make_query(46, 2));
        push_query(make_query(47, 2));
        push_query(make_query(48, 2));
        push_query(make_query(32, 63));
        push_query(make_query(33, 63));
        push_query(make_query(42, 21));
        push_query(make_query(62, 62));
        push_query(make_query(63, 2));
        push_query(make_query(42, 42));
        wait_for_drain();

        for (int i = 0; i < 700; i++) begin
            pick = $urandom_range(0, 9);
            n    = (pick >= 7) ? $urandom_range(40, 63) : $urandom_range(0, 63);
            if (pick < 3)       k = $urandom_range(1, 4);
            else if (pick == 3) k = 0;
            else if (pick == 4) k = 63;
            else                k = $urandom_range(0, 63);
            q = make_query(n, k);
            push_query(q);
            if (i % 150 == 149) wait_for_drain();
        end

        wait_for_drain();
        repeat (70) @(posedge aclk);
        if (miss_count == 0 && due_count == 0) begin
            $display("staircase_ways_counter_unit: match");
        end else begin
            $display("staircase_ways_counter_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/swc_pkg.sv
hdl/swc_table_ram.sv
hdl/staircase_ways_counter_unit.sv
dv/swc_checker.sv
dv/tb_top.sv
